FILE: rtl/core/rc5_pkg.sv
// Package for the RC5-32 block cipher: sequencer states, ALU operation codes,
// the control word and the fixed constants of the scheme.
// No dependencies; imported by rc5_block_cipher and rc5_alu.
package rc5_pkg;

    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 64;
    localparam int KEY_W     = 64;
    localparam int RC_W      = 5;
    localparam int ROT_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam int MIN_ROUNDS = 12;
    localparam int MIX_SHIFT  = 3;

    localparam logic [WORD_W-1:0] RC5_P32 = 32'hB7E1_5163;
    localparam logic [WORD_W-1:0] RC5_Q32 = 32'h9E37_79B9;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd1;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_A,
        ST_MIX_B,
        ST_PRE,
        ST_RUN,
        ST_WB
    } rc5_state_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_ENC,
        ALU_DEC,
        ALU_MIX3,
        ALU_MIXV
    } rc5_alu_op_t;

    typedef struct packed {
        rc5_alu_op_t op;
        logic        wr_subkey;
        logic        wr_key_word;
    } rc5_ctrl_t;

endpackage

FILE: rtl/core/rc5_block_cipher.sv
// RC5-32 block cipher core, ECB, one 64-bit block at a time.
// Depends on rc5_pkg and rc5_alu.
//
// One block is accepted while the core is idle; s_ready then stays low until
// the result is in the output register, so a new block is taken only after the
// last one is through. The single ALU does one half-round per cycle out of the
// subkey memory with its registered read.
// The first block after reset or after a write to the key or round-count
// register first expands the key into the table of T = 2*(R+1) subkeys. Rounds
// below 12 (and zero) run as 12, rounds above MAX_ROUNDS as MAX_ROUNDS. A
// finished result waits in the output register without stopping the next
// block from being accepted.
module rc5_block_cipher
    import rc5_pkg::*;
#(
    parameter int MAX_ROUNDS = 24,
    parameter int KEY_BYTES  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [BLOCK_W-1:0]   s_data_block,
    input  logic                 s_last_in,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BLOCK_W-1:0]   m_out_block,
    output logic                 m_last_out
);

    localparam int TABLE_WORDS = 2 * (MAX_ROUNDS + 1);
    localparam int TW          = $clog2(TABLE_WORDS);
    localparam int KW          = (KEY_BYTES + 3) / 4;
    localparam int KW_W        = $clog2(KW);
    localparam int RND_W       = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W       = (RND_W > RC_W) ? RND_W : RC_W;
    localparam int MAX_T       = (TABLE_WORDS > KW) ? TABLE_WORDS : KW;
    localparam int STEP_W      = $clog2(3 * MAX_T + 1);

    // configuration
    logic [KEY_W-1:0] cipher_key_reg;
    logic [RC_W-1:0]  round_count_reg;
    logic             key_ready_reg, key_ready_set;

    // sequencer and datapath
    rc5_state_t        state_reg, state_next;
    logic [TW-1:0]     idx_reg, idx_next;
    logic [KW_W-1:0]   j_reg, j_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [WORD_W-1:0] ka_reg, ka_next, kb_reg, kb_next;
    logic [WORD_W-1:0] fill_reg, fill_next;
    logic              req_reg, req_next, last_reg, last_next;
    logic              key_load;

    logic [WORD_W-1:0]  subkey_mem [TABLE_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [TW-1:0]      rd_addr;
    logic [WORD_W-1:0]  key_word_reg [KW];

    logic               m_valid_reg, m_valid_next;
    logic [BLOCK_W-1:0] m_out_block_reg, m_out_block_next;
    logic               m_last_out_reg, m_last_out_next;

    rc5_ctrl_t         ctrl;
    logic [WORD_W-1:0] alu_p, alu_q, alu_s, alu_res;

    logic [CMP_W-1:0]  rc_ext;
    logic [RND_W-1:0]  eff_rounds;
    logic [TW-1:0]     last_idx;
    logic [STEP_W-1:0] t_words, mix_span, mix_last;
    logic [TW-1:0]     idx_wrap;
    logic [KW_W-1:0]   j_wrap;
    logic              idx_hi, run_done;

    // effective rounds and derived table bounds
    always_comb begin
        rc_ext = CMP_W'(round_count_reg);
        if (rc_ext < CMP_W'(MIN_ROUNDS)) begin
            eff_rounds = RND_W'(MIN_ROUNDS);
        end else if (rc_ext > CMP_W'(MAX_ROUNDS)) begin
            eff_rounds = RND_W'(MAX_ROUNDS);
        end else begin
            eff_rounds = RND_W'(rc_ext);
        end
        last_idx = TW'({eff_rounds, 1'b1});
        t_words  = STEP_W'(last_idx) + STEP_W'(1);
        mix_span = (t_words > STEP_W'(KW)) ? t_words : STEP_W'(KW);
        mix_last = (mix_span << 1) + mix_span - STEP_W'(1);
        idx_wrap = (idx_reg == last_idx) ? '0 : idx_reg + TW'(1);
        j_wrap   = (j_reg == KW_W'(KW - 1)) ? '0 : j_reg + KW_W'(1);
        idx_hi   = (idx_reg[TW-1:1] != '0);
        run_done = (req_reg == REQ_ENCRYPT) ? (idx_reg == last_idx) : (idx_reg == '0);
    end

    rc5_alu u_alu (
        .op  (ctrl.op),
        .p   (alu_p),
        .q   (alu_q),
        .s   (alu_s),
        .res (alu_res)
    );

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        j_next           = j_reg;
        step_next        = step_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        ka_next          = ka_reg;
        kb_next          = kb_reg;
        fill_next        = fill_reg;
        req_next         = req_reg;
        last_next        = last_reg;
        key_load         = 1'b0;
        key_ready_set    = 1'b0;
        rd_addr          = idx_reg;
        ctrl.op          = ALU_ADD;
        ctrl.wr_subkey   = 1'b0;
        ctrl.wr_key_word = 1'b0;
        alu_p            = fill_reg;
        alu_q            = kb_reg;
        alu_s            = RC5_Q32;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_out_block_next = m_out_block_reg;
        m_last_out_next  = m_last_out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next  = s_req_type;
                    a_next    = s_data_block[WORD_W-1:0];
                    b_next    = s_data_block[BLOCK_W-1:WORD_W];
                    last_next = s_last_in;
                    if (!key_ready_reg) begin
                        key_load   = 1'b1;
                        idx_next   = '0;
                        j_next     = '0;
                        step_next  = '0;
                        ka_next    = '0;
                        kb_next    = '0;
                        fill_next  = RC5_P32;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_PRE;
                    end
                end
            end
            ST_FILL: begin
                // write P + n*Q, fetch entry 0 for mixing on the last beat
                ctrl.wr_subkey = 1'b1;
                fill_next      = alu_res;
                idx_next       = idx_wrap;
                rd_addr        = idx_wrap;
                if (idx_reg == last_idx) begin
                    state_next = ST_MIX_A;
                end
            end
            ST_MIX_A: begin
                ctrl.op        = ALU_MIX3;
                ctrl.wr_subkey = 1'b1;
                alu_p          = ka_reg;
                alu_q          = kb_reg;
                alu_s          = rd_data_reg;
                ka_next        = alu_res;
                state_next     = ST_MIX_B;
            end
            ST_MIX_B: begin
                ctrl.op          = ALU_MIXV;
                ctrl.wr_key_word = 1'b1;
                alu_p            = ka_reg;
                alu_q            = kb_reg;
                alu_s            = key_word_reg[j_reg];
                kb_next          = alu_res;
                idx_next         = idx_wrap;
                j_next           = j_wrap;
                step_next        = step_reg + STEP_W'(1);
                rd_addr          = idx_wrap;
                if (step_reg == mix_last) begin
                    key_ready_set = 1'b1;
                    state_next    = ST_PRE;
                end else begin
                    state_next = ST_MIX_A;
                end
            end
            ST_PRE: begin
                idx_next   = (req_reg == REQ_ENCRYPT) ? '0 : last_idx;
                rd_addr    = idx_next;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                // odd subkeys update B, even ones A
                alu_p = idx_reg[0] ? b_reg : a_reg;
                alu_q = idx_reg[0] ? a_reg : b_reg;
                alu_s = rd_data_reg;
                if (req_reg == REQ_ENCRYPT) begin
                    ctrl.op = idx_hi ? ALU_ENC : ALU_ADD;
                end else begin
                    ctrl.op = idx_hi ? ALU_DEC : ALU_SUB;
                end
                if (idx_reg[0]) begin
                    b_next = alu_res;
                end else begin
                    a_next = alu_res;
                end
                if (run_done) begin
                    state_next = ST_WB;
                end else begin
                    idx_next = (req_reg == REQ_ENCRYPT) ? idx_reg + TW'(1) : idx_reg - TW'(1);
                    rd_addr  = idx_next;
                end
            end
            ST_WB: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_out_block_next = {b_reg, a_reg};
                    m_last_out_next  = last_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            key_ready_reg   <= 1'b0;
            cipher_key_reg  <= '0;
            round_count_reg <= RC_W'(MIN_ROUNDS);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (key_ready_set) begin
                key_ready_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CIPHER_KEY: begin
                        cipher_key_reg <= cfg_wr_data;
                        key_ready_reg  <= 1'b0;
                    end
                    REG_ROUND_COUNT: begin
                        round_count_reg <= cfg_wr_data[RC_W-1:0];
                        key_ready_reg   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        j_reg           <= j_next;
        step_reg        <= step_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        ka_reg          <= ka_next;
        kb_reg          <= kb_next;
        fill_reg        <= fill_next;
        req_reg         <= req_next;
        last_reg        <= last_next;
        m_out_block_reg <= m_out_block_next;
        m_last_out_reg  <= m_last_out_next;
    end

    // subkey table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_subkey) begin
            subkey_mem[idx_reg] <= (state_reg == ST_FILL) ? fill_reg : alu_res;
        end
        rd_data_reg <= subkey_mem[rd_addr];
    end

    // key words: little-endian load, bytes past the eighth read as zero
    always_ff @(posedge aclk) begin
        if (key_load) begin
            for (int n = 0; n < KW; n++) begin
                if (n == 0) begin
                    key_word_reg[n] <= cipher_key_reg[WORD_W-1:0];
                end else if (n == 1) begin
                    key_word_reg[n] <= cipher_key_reg[KEY_W-1:WORD_W];
                end else begin
                    key_word_reg[n] <= '0;
                end
            end
        end else if (ctrl.wr_key_word) begin
            key_word_reg[j_reg] <= alu_res;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_out_block = m_out_block_reg;
    assign m_last_out  = m_last_out_reg;

endmodule

FILE: rtl/core/rc5_alu.sv
// Shared RC5 arithmetic unit: add/sub, one rotator and the half-round forms.
// Used for the table fill, key mixing and every cipher half-round.
// Depends on rc5_pkg.
module rc5_alu
    import rc5_pkg::*;
(
    input  rc5_alu_op_t       op,
    input  logic [WORD_W-1:0] p,
    input  logic [WORD_W-1:0] q,
    input  logic [WORD_W-1:0] s,
    output logic [WORD_W-1:0] res
);

    logic [WORD_W-1:0]   sum3;
    logic [ROT_W-1:0]    amt_mix;
    logic [WORD_W-1:0]   rot_in;
    logic [ROT_W-1:0]    rot_amt;
    logic [2*WORD_W-1:0] rot_wide;
    logic [WORD_W-1:0]   rot_out;

    always_comb begin
        sum3    = s + p + q;
        amt_mix = p[ROT_W-1:0] + q[ROT_W-1:0];
        case (op)
            ALU_ENC: begin
                rot_in  = p ^ q;
                rot_amt = q[ROT_W-1:0];
            end
            ALU_DEC: begin
                // rotate right by q is rotate left by its negation
                rot_in  = p - s;
                rot_amt = ROT_W'(0) - q[ROT_W-1:0];
            end
            ALU_MIXV: begin
                rot_in  = sum3;
                rot_amt = amt_mix;
            end
            default: begin
                rot_in  = sum3;
                rot_amt = ROT_W'(MIX_SHIFT);
            end
        endcase
    end

    assign rot_wide = {rot_in, rot_in} << rot_amt;
    assign rot_out  = rot_wide[2*WORD_W-1:WORD_W];

    always_comb begin
        case (op)
            ALU_ADD:  res = p + s;
            ALU_SUB:  res = p - s;
            ALU_ENC:  res = rot_out + s;
            ALU_DEC:  res = rot_out ^ q;
            default:  res = rot_out;
        endcase
    end

endmodule

FILE: rtl/core/rc5_checker.sv
// Port-level checks for the RC5 core, attached to every instance by bind.
// Depends only on the ports of rc5_block_cipher.
module rc5_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_out_block,
    input logic        m_last_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_block) && $stable(m_last_out))
        else $error("result beat changed while stalled");

    // one block in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a block was in flight");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rc5_block_cipher rc5_checker u_rc5_checker (.*);
